>>> rtl/wmss_pkg.sv
package wmss_pkg;

	localparam int REG_W     = 24;
	localparam int RADIUS_W  = 16;
	localparam int RSQ_W     = 2 * RADIUS_W;
	localparam int REG_IDX_W = 3;
	localparam int FUNC_W    = 2;
	localparam int CMD_W     = 2;
	localparam int MODE_W    = 2;

	localparam logic [FUNC_W-1:0] FUNC_GOAL = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CMD  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_POSE = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd3;

	localparam logic [CMD_W-1:0] CMD_RETURN   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_KEEP_POS = 2'd1;

	localparam logic [MODE_W-1:0] MODE_CODE_HOLD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CODE_TRANSIT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CODE_RETURN  = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_ARRIVE_RADIUS  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HOVER_ALTITUDE = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HOME_X         = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_HOME_Y         = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HOME_Z         = 3'd4;

	localparam logic [RSQ_W-1:0] RADIUS_RESET    = 32'd200;
	localparam logic [RSQ_W-1:0] RADIUS_SQ_RESET = RADIUS_RESET * RADIUS_RESET;
	localparam logic [REG_W-1:0] HOVER_RESET     = 24'd2000;

	typedef enum logic [2:0] {
		MODE_HOLD    = 3'b001,
		MODE_TRANSIT = 3'b010,
		MODE_RETURN  = 3'b100
	} mode_t;

	typedef struct packed {
		logic [RSQ_W-1:0] radius_sq;
		logic [REG_W-1:0] hover;
		logic [REG_W-1:0] home_x;
		logic [REG_W-1:0] home_y;
		logic [REG_W-1:0] home_z;
	} cfg_t;

endpackage

>>> rtl/wmss_cfg.sv
module wmss_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [wmss_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [wmss_pkg::REG_W-1:0]        wr_data,
	output wmss_pkg::cfg_t                    cfg
);

	logic [wmss_pkg::RSQ_W-1:0] radius_sq_q;
	logic [wmss_pkg::REG_W-1:0] hover_q;
	logic [wmss_pkg::REG_W-1:0] home_x_q;
	logic [wmss_pkg::REG_W-1:0] home_y_q;
	logic [wmss_pkg::REG_W-1:0] home_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_sq_q <= wmss_pkg::RADIUS_SQ_RESET;
			hover_q     <= wmss_pkg::HOVER_RESET;
			home_x_q    <= '0;
			home_y_q    <= '0;
			home_z_q    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				wmss_pkg::REG_ARRIVE_RADIUS: begin
					radius_sq_q <= wmss_pkg::RSQ_W'(wr_data[wmss_pkg::RADIUS_W-1:0]) *
						wmss_pkg::RSQ_W'(wr_data[wmss_pkg::RADIUS_W-1:0]);
				end
				wmss_pkg::REG_HOVER_ALTITUDE: hover_q  <= wr_data;
				wmss_pkg::REG_HOME_X:         home_x_q <= wr_data;
				wmss_pkg::REG_HOME_Y:         home_y_q <= wr_data;
				wmss_pkg::REG_HOME_Z:         home_z_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg.radius_sq = radius_sq_q;
	assign cfg.hover     = hover_q;
	assign cfg.home_x    = home_x_q;
	assign cfg.home_y    = home_y_q;
	assign cfg.home_z    = home_z_q;

endmodule

>>> rtl/wmss_core.sv
module wmss_core #(
	parameter int COORD_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  wmss_pkg::cfg_t                       cfg,
	input  logic [wmss_pkg::FUNC_W-1:0]          func,
	input  logic signed [COORD_BITS-1:0]         pos_x,
	input  logic signed [COORD_BITS-1:0]         pos_y,
	input  logic signed [COORD_BITS-1:0]         pos_z,
	input  logic [wmss_pkg::CMD_W-1:0]           cmd,
	output logic                                 res_valid,
	output logic signed [COORD_BITS-1:0]         res_x,
	output logic signed [COORD_BITS-1:0]         res_y,
	output logic signed [COORD_BITS-1:0]         res_z,
	output logic [wmss_pkg::MODE_W-1:0]          res_mode
);

	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int SUM_W = SQ_W + 2;

	wmss_pkg::mode_t mode_q, mode_d;
	logic pose_q, pose_d;
	logic signed [COORD_BITS-1:0] cur_q [3];
	logic signed [COORD_BITS-1:0] cur_d [3];
	logic signed [COORD_BITS-1:0] tgt_q [3];
	logic signed [COORD_BITS-1:0] tgt_d [3];
	logic signed [COORD_BITS-1:0] pos [3];
	logic signed [COORD_BITS-1:0] home [3];
	logic signed [COORD_BITS-1:0] sel [3];
	logic signed [COORD_BITS-1:0] hover_c;
	logic signed [COORD_BITS:0] diff [3];
	logic [COORD_BITS-1:0] mag [3];
	logic [SQ_W-1:0] sq [3];
	logic [SUM_W-1:0] dist2;
	logic arrive;

	always_comb begin
		pos[0]  = pos_x;
		pos[1]  = pos_y;
		pos[2]  = pos_z;
		home[0] = COORD_BITS'(64'(signed'(cfg.home_x)));
		home[1] = COORD_BITS'(64'(signed'(cfg.home_y)));
		home[2] = COORD_BITS'(64'(signed'(cfg.home_z)));
		hover_c = COORD_BITS'(64'(signed'(cfg.hover)));

		case (mode_q)
			wmss_pkg::MODE_RETURN: sel = home;
			wmss_pkg::MODE_HOLD:   sel = cur_q;
			default:               sel = tgt_q;
		endcase

		for (int i = 0; i < 3; i++) begin
			diff[i] = (COORD_BITS+1)'(sel[i]) - (COORD_BITS+1)'(cur_q[i]);
			mag[i]  = diff[i][COORD_BITS] ? COORD_BITS'(-diff[i]) : COORD_BITS'(diff[i]);
			sq[i]   = SQ_W'(mag[i]) * SQ_W'(mag[i]);
		end
		dist2  = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
		arrive = dist2 <= SUM_W'(cfg.radius_sq);

		mode_d    = mode_q;
		pose_d    = pose_q;
		cur_d     = cur_q;
		tgt_d     = tgt_q;
		res_valid = 1'b0;

		case (func)
			wmss_pkg::FUNC_GOAL: begin
				tgt_d[0] = pos[0];
				tgt_d[1] = pos[1];
				tgt_d[2] = (pos[2] == '0) ? hover_c : pos[2];
				mode_d   = wmss_pkg::MODE_TRANSIT;
			end
			wmss_pkg::FUNC_CMD: begin
				case (cmd)
					wmss_pkg::CMD_RETURN: mode_d = wmss_pkg::MODE_RETURN;
					wmss_pkg::CMD_KEEP_POS: begin
						tgt_d  = cur_q;
						mode_d = wmss_pkg::MODE_HOLD;
					end
					default: ;
				endcase
			end
			wmss_pkg::FUNC_POSE: begin
				cur_d  = pos;
				pose_d = 1'b1;
			end
			wmss_pkg::FUNC_TICK: begin
				if (pose_q) begin
					res_valid = 1'b1;
					if (arrive) begin
						mode_d = wmss_pkg::MODE_HOLD;
					end
				end
			end
			default: ;
		endcase

		case (mode_d)
			wmss_pkg::MODE_TRANSIT: res_mode = wmss_pkg::MODE_CODE_TRANSIT;
			wmss_pkg::MODE_RETURN:  res_mode = wmss_pkg::MODE_CODE_RETURN;
			default:                res_mode = wmss_pkg::MODE_CODE_HOLD;
		endcase
	end

	assign res_x = sel[0];
	assign res_y = sel[1];
	assign res_z = sel[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= wmss_pkg::MODE_HOLD;
			pose_q <= 1'b0;
			cur_q  <= '{default: '0};
			tgt_q  <= '{default: '0};
		end else if (en) begin
			mode_q <= mode_d;
			pose_q <= pose_d;
			cur_q  <= cur_d;
			tgt_q  <= tgt_d;
		end
	end

endmodule

>>> rtl/waypoint_mode_setpoint_selector.sv
// Flight setpoint selector. Events (goal, command, pose, tick) enter on the s_ stream, the
// kind in s_tuser; one event is taken every cycle unless a tick that gives a result waits
// for the output register to be free. An event is registered at its transfer; when it
// advances, the mode and point state update and a tick's setpoint is loaded into the output
// register that drives m_tdata. Only a tick after the first pose gives a result; other
// events give none. The update of the mode register from the registered event sets the
// one-event-per-cycle rate; the output register lets a next event that gives no result
// proceed while a result still waits. Write configuration only when no event is in flight.
module waypoint_mode_setpoint_selector #(
	parameter int COORD_BITS = 24,
	localparam int DATA_W = ((3 * COORD_BITS + wmss_pkg::CMD_W + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// pos_x, pos_y, pos_z, command_code, zero padding
	input  logic [DATA_W-1:0]                 s_tdata,
	// func
	input  logic [wmss_pkg::FUNC_W-1:0]       s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// goal_x, goal_y, goal_z, mode_after, zero padding
	output logic [DATA_W-1:0]                 m_tdata,
	input  logic                              wr_en,
	input  logic [wmss_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [wmss_pkg::REG_W-1:0]        wr_data
);

	wmss_pkg::cfg_t cfg;

	logic valid_s1;
	logic [wmss_pkg::FUNC_W-1:0] func_s1;
	logic signed [COORD_BITS-1:0] x_s1, y_s1, z_s1;
	logic [wmss_pkg::CMD_W-1:0] cmd_s1;

	logic valid_s2;
	logic signed [COORD_BITS-1:0] x_s2, y_s2, z_s2;
	logic [wmss_pkg::MODE_W-1:0] mode_s2;

	logic res_valid;
	logic signed [COORD_BITS-1:0] res_x, res_y, res_z;
	logic [wmss_pkg::MODE_W-1:0] res_mode;
	logic out_free, advance;

	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && (!res_valid || out_free);
	assign s_tready = !valid_s1 || advance;

	wmss_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	wmss_core #(.COORD_BITS(COORD_BITS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.cfg       (cfg),
		.func      (func_s1),
		.pos_x     (x_s1),
		.pos_y     (y_s1),
		.pos_z     (z_s1),
		.cmd       (cmd_s1),
		.res_valid (res_valid),
		.res_x     (res_x),
		.res_y     (res_y),
		.res_z     (res_z),
		.res_mode  (res_mode)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			x_s1    <= s_tdata[COORD_BITS-1:0];
			y_s1    <= s_tdata[2*COORD_BITS-1:COORD_BITS];
			z_s1    <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
			cmd_s1  <= s_tdata[3*COORD_BITS +: wmss_pkg::CMD_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res_valid) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			x_s2    <= res_x;
			y_s2    <= res_y;
			z_s2    <= res_z;
			mode_s2 <= res_mode;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = DATA_W'({mode_s2, z_s2, y_s2, x_s2});

endmodule

>>> rtl/wmss_chk.sv
module wmss_chk #(
	parameter int COORD_BITS = 24,
	localparam int DATA_W = ((3 * COORD_BITS + wmss_pkg::CMD_W + 7) / 8) * 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata
);

	logic [wmss_pkg::MODE_W-1:0] mode_field;

	assign mode_field = m_tdata[3*COORD_BITS +: wmss_pkg::MODE_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> mode_field == wmss_pkg::MODE_CODE_HOLD ||
			mode_field == wmss_pkg::MODE_CODE_TRANSIT ||
			mode_field == wmss_pkg::MODE_CODE_RETURN)
		else $error("mode_after carries an undefined code");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a matching input transfer");

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output is ready");

endmodule

bind waypoint_mode_setpoint_selector wmss_chk #(.COORD_BITS(COORD_BITS)) u_wmss_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> bench/tb_waypoint_mode_setpoint_selector.sv
module tb_waypoint_mode_setpoint_selector;
	timeunit 1ns;
	timeprecision 1ps;

	import wmss_pkg::*;

	localparam int COORD_BITS       = 24;
	localparam int DATA_W           = ((3 * COORD_BITS + CMD_W + 7) / 8) * 8;
	localparam int SETTLE_CYCLES    = 4;
	localparam int HOLD_OFF_CYCLES  = 300;
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int RANDOM_PHASES    = 6;
	localparam int ITEMS_PER_PHASE  = 315;

	localparam logic [CMD_W-1:0] CMD_SPARE_A = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SPARE_B = 2'd3;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	localparam coord_t COORD_MAX = coord_t'(2 ** (COORD_BITS - 1) - 1);
	localparam coord_t COORD_MIN = coord_t'(-(2 ** (COORD_BITS - 1)));

	typedef struct {
		coord_t             x;
		coord_t             y;
		coord_t             z;
		logic [MODE_W-1:0]  mode;
	} setpoint_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	// pos_x, pos_y, pos_z, command_code, zero padding
	logic [DATA_W-1:0]  s_tdata = '0;
	// func
	logic [FUNC_W-1:0]  s_tuser = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	// goal_x, goal_y, goal_z, mode_after, zero padding
	logic [DATA_W-1:0]  m_tdata;
	logic               wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [REG_W-1:0]   wr_data = '0;

	// shadow of the block's state and registers
	logic [RADIUS_W-1:0] cfg_radius;
	coord_t              cfg_hover;
	coord_t              cfg_home [3];
	logic [MODE_W-1:0]   sp_mode;
	logic                sp_pose_seen;
	coord_t              sp_current [3];
	coord_t              sp_target [3];

	setpoint_t   pending_setpoints [$];
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;
	int          burst_left = 0;
	logic        hold_off_req = 1'b0;

	waypoint_mode_setpoint_selector #(
		.COORD_BITS(COORD_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void track_flight_state(input logic [FUNC_W-1:0] func, input coord_t x,
			input coord_t y, input coord_t z, input logic [CMD_W-1:0] cmd);
		coord_t            sel [3];
		longint            delta;
		longint unsigned   dist2;
		longint unsigned   radius_sq;
		setpoint_t         sp;
		case (func)
			FUNC_GOAL: begin
				sp_target[0] = x;
				sp_target[1] = y;
				sp_target[2] = (z == 0) ? cfg_hover : z;
				sp_mode = MODE_CODE_TRANSIT;
			end
			FUNC_CMD: begin
				if (cmd == CMD_RETURN) begin
					sp_mode = MODE_CODE_RETURN;
				end else if (cmd == CMD_KEEP_POS) begin
					sp_target = sp_current;
					sp_mode = MODE_CODE_HOLD;
				end
			end
			FUNC_POSE: begin
				sp_current[0] = x;
				sp_current[1] = y;
				sp_current[2] = z;
				sp_pose_seen = 1'b1;
			end
			default: begin
				if (sp_pose_seen) begin
					if (sp_mode == MODE_CODE_RETURN)
						sel = cfg_home;
					else if (sp_mode == MODE_CODE_HOLD)
						sel = sp_current;
					else
						sel = sp_target;
					dist2 = 0;
					for (int i = 0; i < 3; i++) begin
						delta = longint'(sel[i]) - longint'(sp_current[i]);
						dist2 += longint'(delta * delta);
					end
					radius_sq = cfg_radius;
					radius_sq = radius_sq * radius_sq;
					if (dist2 <= radius_sq)
						sp_mode = MODE_CODE_HOLD;
					sp.x = sel[0];
					sp.y = sel[1];
					sp.z = sel[2];
					sp.mode = sp_mode;
					pending_setpoints.push_back(sp);
				end
			end
		endcase
	endfunction

	function automatic coord_t jitter(input coord_t base, input int spread);
		int off;
		off = int'($urandom_range(0, 2 * spread)) - spread;
		return coord_t'(base + off);
	endfunction

	function automatic coord_t wide_coord();
		case ($urandom_range(0, 3))
			0: return coord_t'($urandom);
			1: return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
			default: return coord_t'(int'($urandom_range(0, 600)) - 300);
		endcase
	endfunction

	task automatic offer_event(input logic [FUNC_W-1:0] func, input coord_t x, input coord_t y,
			input coord_t z, input logic [CMD_W-1:0] cmd);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = func;
		s_tdata = DATA_W'({cmd, z, y, x});
		do @(posedge clk); while (!s_tready);
		track_flight_state(func, x, y, z, cmd);
	endtask

	task automatic offer_tick();
		offer_event(FUNC_TICK, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			CMD_W'($urandom));
	endtask

	task automatic offer_command(input logic [CMD_W-1:0] cmd);
		offer_event(FUNC_CMD, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), cmd);
	endtask

	task automatic offer_random_event();
		logic [FUNC_W-1:0] func;
		coord_t            p [3];
		int                pick;
		int                spread;
		int                style;
		pick = $urandom_range(0, 99);
		spread = $urandom_range(0, 300);
		style = $urandom_range(0, 3);
		for (int i = 0; i < 3; i++)
			p[i] = coord_t'($urandom);
		if (pick < 35) begin
			func = FUNC_TICK;
		end else if (pick < 65) begin
			func = FUNC_POSE;
			for (int i = 0; i < 3; i++) begin
				case (style)
					0, 1: p[i] = jitter(sp_target[i], spread);
					2: p[i] = jitter(cfg_home[i], spread);
					default: p[i] = wide_coord();
				endcase
			end
		end else if (pick < 85) begin
			func = FUNC_GOAL;
			for (int i = 0; i < 3; i++)
				p[i] = (style < 2) ? jitter(sp_current[i], spread) : wide_coord();
			if ($urandom_range(0, 7) == 0)
				p[2] = '0;
		end else begin
			func = FUNC_CMD;
		end
		offer_event(func, p[0], p[1], p[2], CMD_W'($urandom));
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		@(posedge clk);
		case (idx)
			REG_ARRIVE_RADIUS:  cfg_radius = data[RADIUS_W-1:0];
			REG_HOVER_ALTITUDE: cfg_hover = data;
			REG_HOME_X:         cfg_home[0] = data;
			REG_HOME_Y:         cfg_home[1] = data;
			REG_HOME_Z:         cfg_home[2] = data;
			default: ;
		endcase
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic apply_settings(input logic [RADIUS_W-1:0] radius, input coord_t hover,
			input coord_t hx, input coord_t hy, input coord_t hz);
		write_reg(REG_ARRIVE_RADIUS, {8'($urandom), radius});
		write_reg(REG_HOVER_ALTITUDE, hover);
		write_reg(REG_HOME_X, hx);
		write_reg(REG_HOME_Y, hy);
		write_reg(REG_HOME_Z, hz);
	endtask

	task automatic drain_and_settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_setpoints.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reset_block();
		cfg_radius = RADIUS_RESET[RADIUS_W-1:0];
		cfg_hover = HOVER_RESET;
		sp_mode = MODE_CODE_HOLD;
		sp_pose_seen = 1'b0;
		for (int i = 0; i < 3; i++) begin
			cfg_home[i] = '0;
			sp_current[i] = '0;
			sp_target[i] = '0;
		end
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	endtask

	task automatic test_tick_before_pose();
		offer_tick();
		offer_event(FUNC_GOAL, 5, -5, 0, CMD_W'($urandom));
		offer_command(CMD_RETURN);
		offer_tick();
		offer_command(CMD_KEEP_POS);
		offer_tick();
		drain_and_settle();
	endtask

	task automatic test_modes_and_arrival();
		offer_event(FUNC_POSE, COORD_MAX, COORD_MAX, COORD_MAX, CMD_W'($urandom));
		offer_tick();
		offer_event(FUNC_GOAL, COORD_MIN, COORD_MIN, COORD_MIN, CMD_W'($urandom));
		offer_tick();
		offer_event(FUNC_GOAL, 0, 0, 0, CMD_W'($urandom));
		offer_event(FUNC_POSE, 10, -10, 1990, CMD_W'($urandom));
		offer_tick();
		offer_command(CMD_SPARE_A);
		offer_command(CMD_SPARE_B);
		offer_tick();
		offer_event(FUNC_POSE, 0, 0, 5, CMD_W'($urandom));
		offer_event(FUNC_GOAL, 200, 0, 5, CMD_W'($urandom));
		offer_tick();
		offer_event(FUNC_GOAL, 201, 0, 5, CMD_W'($urandom));
		offer_tick();
		offer_event(FUNC_POSE, 1000, 0, -1, CMD_W'($urandom));
		offer_command(CMD_RETURN);
		offer_tick();
		offer_command(CMD_KEEP_POS);
		offer_tick();
		drain_and_settle();
	endtask

	task automatic test_register_extremes();
		apply_settings('0, COORD_MIN, COORD_MAX, COORD_MIN, -1);
		for (int i = int'(REG_HOME_Z) + 1; i < 2 ** REG_IDX_W; i++)
			write_reg(REG_IDX_W'(i), REG_W'($urandom));
		offer_event(FUNC_GOAL, 7, 8, 0, CMD_W'($urandom));
		offer_event(FUNC_POSE, 7, 8, COORD_MIN, CMD_W'($urandom));
		offer_tick();
		offer_command(CMD_RETURN);
		offer_tick();
		drain_and_settle();
		apply_settings('1, COORD_MAX, 3, -4, 5);
		offer_event(FUNC_GOAL, 1, 1, 0, CMD_W'($urandom));
		offer_tick();
		offer_command(CMD_RETURN);
		offer_tick();
		drain_and_settle();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: apply_settings(RADIUS_RESET[RADIUS_W-1:0], HOVER_RESET, 0, 0, 0);
				1: apply_settings('0, coord_t'($urandom), jitter(0, 500), jitter(0, 500),
						jitter(0, 500));
				2: apply_settings('1, COORD_MAX, COORD_MAX, COORD_MIN, 0);
				3: apply_settings(RADIUS_W'($urandom_range(0, 1000)), COORD_MIN,
						jitter(0, 300), jitter(0, 300), jitter(0, 300));
				4: apply_settings(1, 0, -1, -1, -1);
				default: apply_settings(RADIUS_W'($urandom), coord_t'($urandom),
						coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
			endcase
			repeat (ITEMS_PER_PHASE) offer_random_event();
			drain_and_settle();
		end
	endtask

	task automatic test_output_backpressure();
		hold_off_req = 1'b1;
		offer_event(FUNC_POSE, jitter(0, 300), jitter(0, 300), jitter(0, 300),
			CMD_W'($urandom));
		for (int k = 0; k < 48; k++) begin
			if (k % 3 == 0)
				offer_random_event();
			else
				offer_tick();
		end
		drain_and_settle();
	endtask

	task automatic check_setpoint();
		setpoint_t want;
		setpoint_t got;
		got.x = m_tdata[0 +: COORD_BITS];
		got.y = m_tdata[COORD_BITS +: COORD_BITS];
		got.z = m_tdata[2 * COORD_BITS +: COORD_BITS];
		got.mode = m_tdata[3 * COORD_BITS +: MODE_W];
		if (pending_setpoints.size() == 0) begin
			$error("setpoint transfer with none expected: %0d %0d %0d mode %0d",
				got.x, got.y, got.z, got.mode);
			error_count++;
		end else begin
			want = pending_setpoints.pop_front();
			if (got.x !== want.x) begin
				$error("goal_x: expected %0d, got %0d", want.x, got.x);
				error_count++;
			end
			if (got.y !== want.y) begin
				$error("goal_y: expected %0d, got %0d", want.y, got.y);
				error_count++;
			end
			if (got.z !== want.z) begin
				$error("goal_z: expected %0d, got %0d", want.z, got.z);
				error_count++;
			end
			if (got.mode !== want.mode) begin
				$error("mode_after: expected %0d, got %0d", want.mode, got.mode);
				error_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_setpoint();
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : receiver
		int style;
		int span;
		int count;
		count = 0;
		forever begin
			style = $urandom_range(0, 3);
			span = $urandom_range(16, 256);
			repeat (span) begin
				@(negedge clk);
				if (hold_off_req) begin
					m_tready = 1'b0;
					repeat (HOLD_OFF_CYCLES) @(negedge clk);
					hold_off_req = 1'b0;
				end
				case (style)
					0: m_tready = 1'b1;
					1: m_tready = 1'($urandom_range(0, 1));
					2: m_tready = ($urandom_range(0, 3) == 0);
					default: m_tready = (count % 4 != 3);
				endcase
				count++;
			end
		end
	end

	initial begin
		reset_block();
		test_tick_before_pose();
		test_modes_and_arrival();
		test_register_extremes();
		test_random_traffic();
		test_output_backpressure();
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/wmss_pkg.sv
rtl/wmss_cfg.sv
rtl/wmss_core.sv
rtl/waypoint_mode_setpoint_selector.sv
rtl/wmss_chk.sv
bench/tb_waypoint_mode_setpoint_selector.sv
